@@ rtl/kpg_pkg.sv @@
// Package for the keypad password gate.
// Holds field widths, event and phase codes, key codes and shared structs.
// No dependencies.
package kpg_pkg;

  localparam int unsigned MaxDigits  = 8;
  localparam int unsigned KeyW       = 8;
  localparam int unsigned HourW      = 5;
  localparam int unsigned EventW     = 3;
  localparam int unsigned CountW     = 4;
  localparam int unsigned FailW      = 3;
  localparam int unsigned DigitW     = 4;
  localparam int unsigned CodeW      = 32;
  localparam int unsigned LimitW     = 3;
  localparam int unsigned PhaseW     = 2;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 32;
  localparam int unsigned InDataW    = 16;
  localparam int unsigned OutDataW   = 16;
  localparam int unsigned StoreIdxW  = $clog2(MaxDigits);

  localparam logic [EventW-1:0] EvIgnored = 3'd0;
  localparam logic [EventW-1:0] EvDigit   = 3'd1;
  localparam logic [EventW-1:0] EvErased  = 3'd2;
  localparam logic [EventW-1:0] EvAwait   = 3'd3;
  localparam logic [EventW-1:0] EvGranted = 3'd4;
  localparam logic [EventW-1:0] EvRetry   = 3'd5;
  localparam logic [EventW-1:0] EvLockout = 3'd6;
  localparam logic [EventW-1:0] EvOutside = 3'd7;

  localparam logic [PhaseW-1:0] PhIdle    = 2'd0;
  localparam logic [PhaseW-1:0] PhCollect = 2'd1;
  localparam logic [PhaseW-1:0] PhConfirm = 2'd2;

  localparam logic [KeyW-1:0] KeyZero  = 8'h30;
  localparam logic [KeyW-1:0] KeyNine  = 8'h39;
  localparam logic [KeyW-1:0] KeyErase = 8'h43;
  localparam logic [KeyW-1:0] KeyEnter = 8'h2B;
  localparam logic [KeyW-1:0] KeyStart = 8'h2F;

  localparam logic [FailW-1:0] FailMax = 3'd7;

  localparam logic [CfgIdxW-1:0] CfgOpenHour    = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgCloseHour   = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgCodeDigits  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgCodeLength  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgAttemptLim  = 3'd4;

  typedef struct packed {
    logic [HourW-1:0]  open_hour;
    logic [HourW-1:0]  close_hour;
    logic [CodeW-1:0]  code_digits;
    logic [CountW-1:0] code_length;
    logic [LimitW-1:0] attempt_limit;
  } cfg_t;

  typedef struct packed {
    logic              logged_in;
    logic [FailW-1:0]  attempts_failed;
    logic [CountW-1:0] digits_entered;
    logic [EventW-1:0] event_res;
  } result_t;

endpackage

@@ rtl/keypad_password_gate_top.sv @@
// A request is held in the input register and its result in the result register.
// Throughput: one key request per cycle while results are taken; the core logic sits
// between the input register and the result register, and a stalled result register
// blocks new requests only once the input register also holds one.
// Reset (rst_ni low, asynchronous): both registers empty, phase idle, counts and
// login flag cleared, configuration back to its default values.
// Depends on kpg_pkg, kpg_cfg_regs and kpg_core.
module keypad_password_gate_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [kpg_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [kpg_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [7:0] key_code, [12:8] current_hour, [15:13] zero
  input  logic [kpg_pkg::InDataW-1:0]   s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [2:0] event_res, [6:3] digits_entered, [9:7] attempts_failed, [10] logged_in,
  // [15:11] zero
  output logic [kpg_pkg::OutDataW-1:0]  m_axis_tdata
);

  kpg_pkg::cfg_t    cfg;
  kpg_pkg::result_t res;

  logic                        in_valid_q;
  logic [kpg_pkg::KeyW-1:0]    key_q;
  logic [kpg_pkg::HourW-1:0]   hour_q;
  logic                        out_valid_q;
  kpg_pkg::result_t            out_q;
  logic                        out_free;
  logic                        step;
  logic                        in_take;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign step          = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  kpg_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  kpg_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .key_i  (key_q),
    .hour_i (hour_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (step) begin
        in_valid_q <= 1'b0;
      end
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      key_q  <= s_axis_tdata[kpg_pkg::KeyW-1:0];
      hour_q <= s_axis_tdata[kpg_pkg::KeyW +: kpg_pkg::HourW];
    end
    if (step) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = kpg_pkg::OutDataW'(out_q);

endmodule

@@ rtl/kpg_cfg_regs.sv @@
// Configuration register file for the keypad password gate.
// Depends on kpg_pkg for register indexes, widths and cfg_t.
module kpg_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [kpg_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [kpg_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output kpg_pkg::cfg_t                 cfg_o
);

  kpg_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        kpg_pkg::CfgOpenHour:   cfg_d.open_hour     = cfg_wdata_i[kpg_pkg::HourW-1:0];
        kpg_pkg::CfgCloseHour:  cfg_d.close_hour    = cfg_wdata_i[kpg_pkg::HourW-1:0];
        kpg_pkg::CfgCodeDigits: cfg_d.code_digits   = cfg_wdata_i[kpg_pkg::CodeW-1:0];
        kpg_pkg::CfgCodeLength: cfg_d.code_length   = cfg_wdata_i[kpg_pkg::CountW-1:0];
        kpg_pkg::CfgAttemptLim: cfg_d.attempt_limit = cfg_wdata_i[kpg_pkg::LimitW-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.open_hour     <= 5'd2;
      cfg_q.close_hour    <= 5'd8;
      cfg_q.code_digits   <= 32'h0000_4321;
      cfg_q.code_length   <= 4'd4;
      cfg_q.attempt_limit <= 3'd3;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/kpg_core.sv @@
// Entry state machine, digit buffer and code compare for the keypad password gate.
// Depends on kpg_pkg for codes, widths, cfg_t and result_t.
module kpg_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_i,
  input  logic [kpg_pkg::KeyW-1:0]    key_i,
  input  logic [kpg_pkg::HourW-1:0]   hour_i,
  input  kpg_pkg::cfg_t               cfg_i,
  output kpg_pkg::result_t            res_o
);

  logic [kpg_pkg::PhaseW-1:0] phase_q, phase_d;
  logic [kpg_pkg::CountW-1:0] count_q, count_d;
  logic [kpg_pkg::FailW-1:0]  fail_q, fail_d;
  logic                       login_q, login_d;
  logic [kpg_pkg::DigitW-1:0] store_q [kpg_pkg::MaxDigits];
  logic                       store_we;
  logic [kpg_pkg::StoreIdxW-1:0] store_idx;
  logic [kpg_pkg::DigitW-1:0] store_wdata;
  logic [kpg_pkg::EventW-1:0] ev;
  logic                       is_digit;
  logic                       in_window;
  logic                       match;
  logic [kpg_pkg::FailW-1:0]  fail_inc;

  assign is_digit  = (key_i >= kpg_pkg::KeyZero) && (key_i <= kpg_pkg::KeyNine);
  assign in_window = (cfg_i.open_hour <= hour_i) && (hour_i <= cfg_i.close_hour);
  assign store_idx = count_q[kpg_pkg::StoreIdxW-1:0];
  assign store_wdata = kpg_pkg::DigitW'(key_i - kpg_pkg::KeyZero);
  assign fail_inc  = (fail_q < kpg_pkg::FailMax) ? fail_q + 3'd1 : fail_q;

  always_comb begin
    match = (cfg_i.code_length <= kpg_pkg::CountW'(kpg_pkg::MaxDigits))
         && (count_q == cfg_i.code_length);
    for (int k = 0; k < kpg_pkg::MaxDigits; k++) begin
      if ((kpg_pkg::CountW'(k) < count_q)
          && (store_q[k] != cfg_i.code_digits[k*kpg_pkg::DigitW +: kpg_pkg::DigitW])) begin
        match = 1'b0;
      end
    end
  end

  always_comb begin
    phase_d  = phase_q;
    count_d  = count_q;
    fail_d   = fail_q;
    login_d  = login_q;
    store_we = 1'b0;
    ev       = kpg_pkg::EvIgnored;
    case (phase_q)
      kpg_pkg::PhCollect: begin
        if (is_digit) begin
          if (count_q < kpg_pkg::CountW'(kpg_pkg::MaxDigits)) begin
            store_we = 1'b1;
            count_d  = count_q + 4'd1;
            ev       = kpg_pkg::EvDigit;
          end
        end else if (key_i == kpg_pkg::KeyErase) begin
          if (count_q != '0) begin
            count_d = count_q - 4'd1;
            ev      = kpg_pkg::EvErased;
          end
        end else if (key_i == kpg_pkg::KeyEnter) begin
          phase_d = kpg_pkg::PhConfirm;
          ev      = kpg_pkg::EvAwait;
        end
      end
      kpg_pkg::PhConfirm: begin
        if (key_i == kpg_pkg::KeyEnter) begin
          if (match) begin
            login_d = 1'b1;
            phase_d = kpg_pkg::PhIdle;
            ev      = kpg_pkg::EvGranted;
          end else begin
            fail_d = fail_inc;
            if (fail_inc >= cfg_i.attempt_limit) begin
              phase_d = kpg_pkg::PhIdle;
              ev      = kpg_pkg::EvLockout;
            end else begin
              phase_d = kpg_pkg::PhCollect;
              count_d = '0;
              ev      = kpg_pkg::EvRetry;
            end
          end
        end
      end
      default: begin
        phase_d = kpg_pkg::PhIdle;
        if (key_i == kpg_pkg::KeyStart) begin
          if (in_window) begin
            phase_d = kpg_pkg::PhCollect;
            count_d = '0;
            fail_d  = '0;
          end else begin
            ev = kpg_pkg::EvOutside;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= kpg_pkg::PhIdle;
      count_q <= '0;
      fail_q  <= '0;
      login_q <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      count_q <= count_d;
      fail_q  <= fail_d;
      login_q <= login_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i && store_we) begin
      store_q[store_idx] <= store_wdata;
    end
  end

  assign res_o.event_res       = ev;
  assign res_o.digits_entered  = count_d;
  assign res_o.attempts_failed = fail_d;
  assign res_o.logged_in       = login_d;

endmodule

@@ rtl/kpg_checker.sv @@
// Port-level checker for keypad_password_gate_top, attached by bind.
// Depends on kpg_pkg for event codes and widths.
module kpg_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [kpg_pkg::OutDataW-1:0]  m_axis_tdata
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[15:11] == 5'd0) && (m_axis_tdata[6:3] <= 4'd8))
    else $error("result padding or digit count out of range");

  a_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[2:0] == kpg_pkg::EvGranted) |-> m_axis_tdata[10])
    else $error("grant without login flag");

  a_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && ((m_axis_tdata[2:0] == kpg_pkg::EvDigit)
      || (m_axis_tdata[2:0] == kpg_pkg::EvRetry) || (m_axis_tdata[2:0] == kpg_pkg::EvLockout))
    |-> ((m_axis_tdata[2:0] == kpg_pkg::EvDigit) ? (m_axis_tdata[6:3] != 4'd0)
        : ((m_axis_tdata[9:7] != 3'd0) && !((m_axis_tdata[2:0] == kpg_pkg::EvRetry)
           && (m_axis_tdata[6:3] != 4'd0)))))
    else $error("event inconsistent with counts");

endmodule

bind keypad_password_gate_top kpg_checker u_kpg_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

@@ bench/keypad_password_gate_top_tb.sv @@
`timescale 1ns / 1ps
// Testbench for keypad_password_gate_top: keypad requests go in, gate events are checked
// against a behavioral gate model kept in step with each accepted key. Depends on kpg_pkg.
module keypad_password_gate_top_tb;

  localparam int unsigned IdleLimit = 2000;

  logic                         clk_i         = 1'b0;
  logic                         rst_ni        = 1'b0;
  logic                         cfg_we_i      = 1'b0;
  logic [kpg_pkg::CfgIdxW-1:0]  cfg_idx_i     = '0;
  logic [kpg_pkg::CfgDataW-1:0] cfg_wdata_i   = '0;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  // [7:0] key_code, [12:8] current_hour, [15:13] zero
  logic [kpg_pkg::InDataW-1:0]  s_axis_tdata  = '0;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  // [2:0] event_res, [6:3] digits_entered, [9:7] attempts_failed, [10] logged_in, [15:11] zero
  logic [kpg_pkg::OutDataW-1:0] m_axis_tdata;

  logic [kpg_pkg::PhaseW-1:0] gate_phase;
  logic [kpg_pkg::DigitW-1:0] key_digits [kpg_pkg::MaxDigits];
  logic [kpg_pkg::CountW-1:0] key_count;
  logic [kpg_pkg::FailW-1:0]  fail_tally;
  logic                       login_seen;
  logic [kpg_pkg::HourW-1:0]  win_open;
  logic [kpg_pkg::HourW-1:0]  win_close;
  logic [kpg_pkg::CodeW-1:0]  pin_code;
  logic [kpg_pkg::CountW-1:0] pin_len;
  logic [kpg_pkg::LimitW-1:0] fail_limit;

  kpg_pkg::result_t pending_events[$];
  int unsigned items_sent   = 0;
  int unsigned err_cnt      = 0;
  int unsigned idle_cycles  = 0;
  int unsigned tx_idle_pct  = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned rx_hold      = 0;

  always #6 clk_i = ~clk_i;

  keypad_password_gate_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  function automatic bit pin_matches();
    bit ok;
    ok = (pin_len <= kpg_pkg::CountW'(kpg_pkg::MaxDigits)) && (key_count == pin_len);
    for (int k = 0; k < kpg_pkg::MaxDigits; k++) begin
      if (k < key_count
          && key_digits[k] != pin_code[kpg_pkg::DigitW*k +: kpg_pkg::DigitW]) ok = 1'b0;
    end
    return ok;
  endfunction

  function automatic kpg_pkg::result_t gate_step(logic [kpg_pkg::KeyW-1:0] key,
                                                 logic [kpg_pkg::HourW-1:0] hour);
    kpg_pkg::result_t r;
    r = '0;
    r.event_res = kpg_pkg::EvIgnored;
    case (gate_phase)
      kpg_pkg::PhCollect: begin
        if (key >= kpg_pkg::KeyZero && key <= kpg_pkg::KeyNine) begin
          if (key_count < kpg_pkg::CountW'(kpg_pkg::MaxDigits)) begin
            key_digits[key_count[kpg_pkg::StoreIdxW-1:0]] =
              kpg_pkg::DigitW'(key - kpg_pkg::KeyZero);
            key_count = key_count + 1'b1;
            r.event_res = kpg_pkg::EvDigit;
          end
        end else if (key == kpg_pkg::KeyErase) begin
          if (key_count != '0) begin
            key_count = key_count - 1'b1;
            r.event_res = kpg_pkg::EvErased;
          end
        end else if (key == kpg_pkg::KeyEnter) begin
          gate_phase = kpg_pkg::PhConfirm;
          r.event_res = kpg_pkg::EvAwait;
        end
      end
      kpg_pkg::PhConfirm: begin
        if (key == kpg_pkg::KeyEnter) begin
          if (pin_matches()) begin
            login_seen = 1'b1;
            gate_phase = kpg_pkg::PhIdle;
            r.event_res = kpg_pkg::EvGranted;
          end else begin
            if (fail_tally < kpg_pkg::FailMax) fail_tally = fail_tally + 1'b1;
            if (fail_tally >= fail_limit) begin
              gate_phase = kpg_pkg::PhIdle;
              r.event_res = kpg_pkg::EvLockout;
            end else begin
              gate_phase = kpg_pkg::PhCollect;
              key_count = '0;
              r.event_res = kpg_pkg::EvRetry;
            end
          end
        end
      end
      default: begin
        gate_phase = kpg_pkg::PhIdle;
        if (key == kpg_pkg::KeyStart) begin
          if (win_open <= hour && hour <= win_close) begin
            gate_phase = kpg_pkg::PhCollect;
            key_count = '0;
            fail_tally = '0;
          end else begin
            r.event_res = kpg_pkg::EvOutside;
          end
        end
      end
    endcase
    r.digits_entered  = key_count;
    r.attempts_failed = fail_tally;
    r.logged_in       = login_seen;
    return r;
  endfunction

  task automatic send_key(input logic [kpg_pkg::KeyW-1:0] key,
                          input logic [kpg_pkg::HourW-1:0] hour);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= kpg_pkg::InDataW'({hour, key});
    do @(posedge clk_i); while (!s_axis_tready);
    pending_events.push_back(gate_step(key, hour));
    items_sent++;
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [kpg_pkg::CfgIdxW-1:0] idx,
                           input logic [kpg_pkg::CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      kpg_pkg::CfgOpenHour:   win_open   = val[kpg_pkg::HourW-1:0];
      kpg_pkg::CfgCloseHour:  win_close  = val[kpg_pkg::HourW-1:0];
      kpg_pkg::CfgCodeDigits: pin_code   = val;
      kpg_pkg::CfgCodeLength: pin_len    = val[kpg_pkg::CountW-1:0];
      kpg_pkg::CfgAttemptLim: fail_limit = val[kpg_pkg::LimitW-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input int unsigned open_h, input int unsigned close_h,
                            input logic [kpg_pkg::CodeW-1:0] code, input int unsigned len,
                            input int unsigned lim);
    write_reg(kpg_pkg::CfgOpenHour, open_h);
    write_reg(kpg_pkg::CfgCloseHour, close_h);
    write_reg(kpg_pkg::CfgCodeDigits, code);
    write_reg(kpg_pkg::CfgCodeLength, len);
    write_reg(kpg_pkg::CfgAttemptLim, lim);
  endtask

  task automatic enter_attempt(input bit right);
    int unsigned len;
    logic [kpg_pkg::DigitW-1:0] d;
    len = right ? int'(pin_len) : $urandom_range(0, 9);
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(0, 99) < 10) begin
        send_key(kpg_pkg::KeyW'(kpg_pkg::KeyZero + $urandom_range(0, 9)),
                 kpg_pkg::HourW'($urandom_range(0, 31)));
        send_key(kpg_pkg::KeyErase, kpg_pkg::HourW'($urandom_range(0, 31)));
      end
      if ($urandom_range(0, 99) < 4)
        send_key(kpg_pkg::KeyW'($urandom_range(0, 255)), kpg_pkg::HourW'($urandom_range(0, 31)));
      d = (right && k < kpg_pkg::MaxDigits) ? pin_code[kpg_pkg::DigitW*k +: kpg_pkg::DigitW]
                                            : kpg_pkg::DigitW'($urandom_range(0, 9));
      send_key(kpg_pkg::KeyW'(kpg_pkg::KeyZero + d), kpg_pkg::HourW'($urandom_range(0, 31)));
    end
    if ($urandom_range(0, 99) < 5)
      send_key(kpg_pkg::KeyErase, kpg_pkg::HourW'($urandom_range(0, 31)));
    send_key(kpg_pkg::KeyEnter, kpg_pkg::HourW'($urandom_range(0, 31)));
    if ($urandom_range(0, 99) < 10)
      send_key(kpg_pkg::KeyW'($urandom_range(0, 255)), kpg_pkg::HourW'($urandom_range(0, 31)));
    send_key(kpg_pkg::KeyEnter, kpg_pkg::HourW'($urandom_range(0, 31)));
  endtask

  task automatic run_sessions(input int unsigned goal);
    int unsigned stop_at;
    int unsigned tries;
    logic [kpg_pkg::HourW-1:0] hour;
    stop_at = items_sent + goal;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 99) < 80) begin
        if (win_open <= win_close && $urandom_range(0, 99) < 85)
          hour = kpg_pkg::HourW'($urandom_range(win_close, win_open));
        else
          hour = kpg_pkg::HourW'($urandom_range(0, 31));
        send_key(kpg_pkg::KeyStart, hour);
        tries = 0;
        while (gate_phase != kpg_pkg::PhIdle && tries < 10) begin
          enter_attempt($urandom_range(0, 99) < 40);
          tries++;
        end
      end else begin
        send_key(kpg_pkg::KeyW'($urandom_range(0, 255)), kpg_pkg::HourW'($urandom_range(0, 31)));
      end
    end
  endtask

  task automatic test_login_window();
    send_key(kpg_pkg::KeyStart, 5'd1);
    send_key(kpg_pkg::KeyStart, 5'd9);
    send_key(kpg_pkg::KeyStart, 5'd2);
    send_key(kpg_pkg::KeyW'(kpg_pkg::KeyZero + 1), 5'd0);
    send_key(kpg_pkg::KeyW'(kpg_pkg::KeyZero + 2), 5'd31);
    send_key(kpg_pkg::KeyW'(kpg_pkg::KeyZero + 3), 5'd0);
    send_key(kpg_pkg::KeyW'(kpg_pkg::KeyZero + 4), 5'd31);
    send_key(kpg_pkg::KeyEnter, 5'd0);
    send_key(kpg_pkg::KeyEnter, 5'd23);
  endtask

  task automatic test_zero_limit_lockout();
    drain();
    write_reg(kpg_pkg::CfgAttemptLim, 0);
    send_key(kpg_pkg::KeyStart, 5'd8);
    send_key(kpg_pkg::KeyErase, 5'd8);
    send_key(8'hFF, 5'd8);
    send_key(kpg_pkg::KeyNine, 5'd8);
    send_key(kpg_pkg::KeyErase, 5'd8);
    send_key(kpg_pkg::KeyEnter, 5'd8);
    send_key(8'h00, 5'd8);
    send_key(kpg_pkg::KeyEnter, 5'd8);
  endtask

  task automatic test_full_buffer();
    send_key(kpg_pkg::KeyStart, 5'd5);
    for (int k = 0; k <= kpg_pkg::MaxDigits; k++)
      send_key(kpg_pkg::KeyW'(kpg_pkg::KeyZero + k), 5'd5);
  endtask

  task automatic test_backpressure();
    drain();
    set_config(0, 23, 32'h4321, 4, 3);
    @(posedge clk_i);
    rx_hold = 300;
    run_sessions(24);
  endtask

  task automatic test_random_phases();
    logic [kpg_pkg::CodeW-1:0] code;
    int unsigned open_h;
    for (int p = 0; p < 8; p++) begin
      drain();
      case (p % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 54; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 54; end
        default: begin tx_idle_pct = 12; rx_stall_pct = 12; end
      endcase
      case (p)
        1: set_config(0, 31, 32'h9999_9999, kpg_pkg::MaxDigits, 7);
        3: set_config(0, 0, '1, 15, 0);
        5: set_config(31, 0, '0, 0, 1);
        7: set_config(0, 23, '0, 0, 2);
        default: begin
          for (int k = 0; k < kpg_pkg::MaxDigits; k++)
            code[kpg_pkg::DigitW*k +: kpg_pkg::DigitW] = kpg_pkg::DigitW'($urandom_range(0, 9));
          open_h = $urandom_range(0, 20);
          set_config(open_h, $urandom_range(open_h, 23), code,
                     $urandom_range(0, kpg_pkg::MaxDigits), $urandom_range(1, 7));
        end
      endcase
      run_sessions(190);
    end
  endtask

  always @(negedge clk_i) begin
    if (rx_hold != 0) begin
      rx_hold = rx_hold - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    kpg_pkg::result_t want;
    kpg_pkg::result_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = kpg_pkg::result_t'(m_axis_tdata[$bits(kpg_pkg::result_t)-1:0]);
      if (pending_events.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected result, expected none, actual %h", $time, m_axis_tdata);
      end else begin
        want = pending_events.pop_front();
        check_field("event_res", 8'(want.event_res), 8'(got.event_res));
        check_field("digits_entered", 8'(want.digits_entered), 8'(got.digits_entered));
        check_field("attempts_failed", 8'(want.attempts_failed), 8'(got.attempts_failed));
        check_field("logged_in", 8'(want.logged_in), 8'(got.logged_in));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else if (rst_ni) begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("keypad_password_gate_top regression: fail");
        $finish;
      end
    end
  end

  initial begin
    gate_phase = kpg_pkg::PhIdle;
    for (int k = 0; k < kpg_pkg::MaxDigits; k++) key_digits[k] = '0;
    key_count  = '0;
    fail_tally = '0;
    login_seen = 1'b0;
    win_open   = 5'd2;
    win_close  = 5'd8;
    pin_code   = 32'h4321;
    pin_len    = 4'd4;
    fail_limit = 3'd3;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_login_window();
    test_zero_limit_lockout();
    test_full_buffer();
    test_backpressure();
    test_random_phases();
    drain();
    if (err_cnt == 0)
      $display("keypad_password_gate_top regression: pass");
    else
      $display("keypad_password_gate_top regression: fail");
    $finish;
  end

endmodule
